[hdl/mssel_pkg.sv]
// Package for the marginal state set selector: sizes, constants, helper functions.
// No dependencies.
package mssel_pkg;

    localparam int MaxStates = 16;
    localparam int IdxW      = $clog2(MaxStates);
    localparam int CntW      = IdxW + 1;
    localparam int ProbW     = 17;
    localparam int ErrW      = 40;
    localparam logic [ProbW-1:0] OneQ16 = 17'd65536;
    localparam logic [ErrW-1:0]  ErrMax = {ErrW{1'b1}};

    localparam logic [4:0] RegNumStates  = 5'd0;
    localparam logic [4:0] RegSelectMode = 5'd1;

    // q_k = round(65536 / k), k = 1..16, constant table
    function automatic logic [ProbW-1:0] uniform_q(input logic [CntW-1:0] k);
        logic [ProbW-1:0] q;
        case (k)
            5'd1:    q = 17'd65536;
            5'd2:    q = 17'd32768;
            5'd3:    q = 17'd21845;
            5'd4:    q = 17'd16384;
            5'd5:    q = 17'd13107;
            5'd6:    q = 17'd10923;
            5'd7:    q = 17'd9362;
            5'd8:    q = 17'd8192;
            5'd9:    q = 17'd7282;
            5'd10:   q = 17'd6554;
            5'd11:   q = 17'd5958;
            5'd12:   q = 17'd5461;
            5'd13:   q = 17'd5041;
            5'd14:   q = 17'd4681;
            5'd15:   q = 17'd4369;
            5'd16:   q = 17'd4096;
            default: q = 17'd0;
        endcase
        return q;
    endfunction

    typedef struct packed {
        logic load;
        logic clr_rank;
        logic rank_step;
        logic err_init;
        logic err_step;
        logic err_close;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic node_done;
        logic i_last;
        logic j_last;
        logic k_last;
    } stat_t;

endpackage

[hdl/mssel_ctrl.sv]
// Controller for the marginal state set selector: sequences rank, error and emit phases.
// Depends on mssel_pkg.
module mssel_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    input  mssel_pkg::stat_t  stat,
    output mssel_pkg::cmd_t   cmd,
    output logic              busy
);

    typedef enum logic [2:0] {S_IDLE, S_RANK, S_ERR_INIT, S_ERR, S_EMIT} state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start && stat.node_done)
                begin
                    cmd.clr_rank = 1'b1;
                    state_next = S_RANK;
                end
            end
            S_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (stat.i_last && stat.j_last)
                    state_next = mode ? S_EMIT : S_ERR_INIT;
            end
            S_ERR_INIT:
            begin
                cmd.err_init = 1'b1;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_step = 1'b1;
                if (stat.i_last)
                begin
                    cmd.err_close = 1'b1;
                    if (stat.k_last)
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.i_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[hdl/mssel_dp.sv]
// Datapath for the marginal state set selector: store, rank counters, error accumulator.
// Depends on mssel_pkg.
module mssel_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mssel_pkg::cmd_t                 cmd,
    input  logic [4:0]                      cfg_states,
    input  logic                            mode,
    input  logic [mssel_pkg::ProbW-1:0]     in_probability,
    output mssel_pkg::stat_t                stat,
    output logic                            done,
    output logic [mssel_pkg::IdxW-1:0]      state_index,
    output logic [mssel_pkg::ProbW-1:0]     out_probability,
    output logic [mssel_pkg::IdxW-1:0]      state_rank,
    output logic [mssel_pkg::CntW-1:0]      kept_count,
    output logic                            last_of_node
);

    localparam int IW = mssel_pkg::IdxW;
    localparam int CW = mssel_pkg::CntW;
    localparam int PW = mssel_pkg::ProbW;
    localparam int EW = mssel_pkg::ErrW;

    logic [PW-1:0] prob_reg [mssel_pkg::MaxStates];
    logic [IW-1:0] rank_reg [mssel_pkg::MaxStates];
    logic [IW-1:0] order_reg [mssel_pkg::MaxStates];
    logic [CW-1:0] load_reg;
    logic [CW-1:0] n_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic [CW-1:0] k_reg;
    logic [IW-1:0] cnt_reg;
    logic [EW-1:0] acc_reg;
    logic [EW-1:0] best_reg;
    logic [CW-1:0] keep_reg;
    logic [PW-1:0] max_reg;
    logic [IW-1:0] maxi_reg;
    logic          found_reg;

    // effective count clamp
    logic [CW-1:0] n_eff;
    always_comb
    begin
        if (cfg_states == 5'd0)
            n_eff = CW'(1);
        else if (CW'(cfg_states) > CW'(mssel_pkg::MaxStates) || cfg_states[4] && CW > 5)
            n_eff = CW'(mssel_pkg::MaxStates);
        else
            n_eff = CW'(cfg_states);
    end

    logic [CW-1:0] load_inc;
    assign load_inc = load_reg + CW'(1);
    assign stat.node_done = (load_inc >= n_eff);

    logic [CW-1:0] nm1;
    assign nm1 = n_reg - CW'(1);
    assign stat.i_last = ({1'b0, i_reg} == nm1);
    assign stat.j_last = ({1'b0, j_reg} == nm1);
    assign stat.k_last = (k_reg == n_reg);

    // rank compare
    logic [PW-1:0] pi, pj;
    assign pi = prob_reg[i_reg];
    assign pj = prob_reg[j_reg];
    logic beats;
    assign beats = (pj > pi) || ((pj == pi) && (j_reg < i_reg));
    logic [IW-1:0] cnt_new;
    assign cnt_new = cnt_reg + IW'(beats);

    // error term at rank i
    logic [PW-1:0] q, pr, dd;
    assign q  = mssel_pkg::uniform_q(k_reg);
    assign pr = prob_reg[order_reg[i_reg]];
    always_comb
    begin
        if ({1'b0, i_reg} < k_reg)
            dd = (pr >= q) ? pr - q : q - pr;
        else
            dd = pr;
    end
    logic [2*PW-1:0] sq;
    assign sq = dd * dd;
    logic [EW-1:0] acc_new;
    assign acc_new = acc_reg + EW'(sq);

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_reg < CW'(mssel_pkg::MaxStates))
            prob_reg[load_reg[IW-1:0]] <= in_probability;
        if (cmd.rank_step && stat.j_last)
        begin
            rank_reg[i_reg] <= cnt_new;
            order_reg[cnt_new] <= i_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= '0;
            n_reg     <= CW'(1);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= CW'(1);
            cnt_reg   <= '0;
            acc_reg   <= '0;
            best_reg  <= mssel_pkg::ErrMax;
            keep_reg  <= CW'(1);
            max_reg   <= '0;
            maxi_reg  <= '0;
            found_reg <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cmd.load)
                load_reg <= stat.node_done ? '0 : load_inc;
            if (cmd.clr_rank)
            begin
                n_reg     <= n_eff;
                i_reg     <= '0;
                j_reg     <= '0;
                cnt_reg   <= '0;
                max_reg   <= '0;
                maxi_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.rank_step)
            begin
                if (j_reg == '0 && pi > max_reg)
                begin
                    max_reg   <= pi;
                    maxi_reg  <= i_reg;
                    found_reg <= 1'b1;
                end
                if (stat.j_last)
                begin
                    j_reg   <= '0;
                    cnt_reg <= '0;
                    i_reg   <= stat.i_last ? '0 : i_reg + IW'(1);
                    if (stat.i_last && mode)
                        keep_reg <= found_reg || (pi > max_reg) ? CW'(1) : '0;
                end
                else
                begin
                    j_reg   <= j_reg + IW'(1);
                    cnt_reg <= cnt_new;
                end
            end
            if (cmd.err_init)
            begin
                k_reg    <= CW'(1);
                i_reg    <= '0;
                acc_reg  <= '0;
                best_reg <= mssel_pkg::ErrMax;
                keep_reg <= n_reg;
            end
            if (cmd.err_step)
            begin
                if (cmd.err_close)
                begin
                    if (acc_new < best_reg)
                    begin
                        best_reg <= acc_new;
                        keep_reg <= k_reg;
                    end
                    acc_reg <= '0;
                    i_reg   <= '0;
                    k_reg   <= k_reg + CW'(1);
                end
                else
                begin
                    acc_reg <= acc_new;
                    i_reg   <= i_reg + IW'(1);
                end
            end
            if (cmd.emit)
            begin
                done  <= 1'b1;
                i_reg <= stat.i_last ? '0 : i_reg + IW'(1);
            end
        end
    end

    // result regs
    logic [PW-1:0] outp;
    always_comb
    begin
        if (mode)
            outp = (found_reg && i_reg == maxi_reg) ? mssel_pkg::OneQ16 : '0;
        else
            outp = ({1'b0, rank_reg[i_reg]} < keep_reg) ? mssel_pkg::uniform_q(keep_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            state_index     <= i_reg;
            out_probability <= outp;
            state_rank      <= rank_reg[i_reg];
            kept_count      <= keep_reg;
            last_of_node    <= stat.i_last;
        end
    end

endmodule

[hdl/marginal_state_set_selector.sv]
// Marginal state set selector: a node completes on its last item; then ranking runs, in mode 0
// an error search follows, then n results on consecutive cycles, one strobe each.
// Up to num_states items are taken one per cycle while idle; busy ends before the last strobe.
// Receiver cannot stall. Async active-low reset clears control, config to 16 states, mode 0.
// Depends on mssel_pkg, mssel_ctrl, mssel_dp.
module marginal_state_set_selector
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mssel_pkg::ProbW-1:0]         in_probability,
    input  logic                                cfg_we,
    input  logic [4:0]                          cfg_index,
    input  logic [4:0]                          cfg_data,
    output logic                                result_valid,
    output logic [mssel_pkg::IdxW-1:0]          state_index,
    output logic [mssel_pkg::ProbW-1:0]         out_probability,
    output logic [mssel_pkg::IdxW-1:0]          state_rank,
    output logic [mssel_pkg::CntW-1:0]          kept_count,
    output logic                                last_of_node
);

    logic [4:0] states_reg;
    logic       mode_reg;
    mssel_pkg::cmd_t  cmd;
    mssel_pkg::stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_reg <= 5'd16;
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mssel_pkg::RegNumStates)
                states_reg <= cfg_data;
            else if (cfg_index == mssel_pkg::RegSelectMode)
                mode_reg <= cfg_data[0];
        end
    end

    mssel_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode_reg),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mssel_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_states      (states_reg),
        .mode            (mode_reg),
        .in_probability  (in_probability),
        .stat            (stat),
        .done            (result_valid),
        .state_index     (state_index),
        .out_probability (out_probability),
        .state_rank      (state_rank),
        .kept_count      (kept_count),
        .last_of_node    (last_of_node)
    );

    // results only come out of the emit phase
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_node |-> busy)
        else $error("result strobe outside busy");
    // last result of node ends busy
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_node |-> !busy)
        else $error("busy after last result");
    // nonzero output within kept states
    a_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_probability != '0 |-> kept_count != '0)
        else $error("nonzero probability with no kept states");

endmodule
